[src/bts_pkg.sv]
// shared constants and types of the bilinear texture sampler
`default_nettype none

package bts_pkg;

   localparam int TEXEL_COUNT_DEF   = 65536;
   localparam int MAX_SIZE_LOG2_DEF = 8;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_LOG2  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_LOG2 = 1'b1;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam int ADDR_IN_W  = 16;
   localparam int COORD_W    = 32;
   localparam int FRAC_W     = 16;
   localparam int WEIGHT_W   = FRAC_W + 1;
   localparam int TEXEL_W    = 32;
   localparam int CHAN_W     = 8;
   localparam int CHAN_COUNT = 4;
   localparam int TAP_COUNT  = 4;
   localparam int LERP_W     = 24;
   localparam int PROD_W     = 40;
   localparam int RESULT_W   = 16;
   localparam int ROUND_POS  = 24;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;
   localparam logic [PROD_W-1:0]   ROUND_HALF = PROD_W'(1) << (ROUND_POS - 1);

   typedef struct packed {
      logic              is_sample;
      logic [FRAC_W-1:0] dx;
      logic [FRAC_W-1:0] dy;
   } bts_ctl_type;

   typedef logic [TAP_COUNT-1:0][TEXEL_W-1:0]   bts_taps_type;
   typedef logic [CHAN_COUNT-1:0][RESULT_W-1:0] bts_chan_type;

endpackage

`default_nettype wire

[src/bts_req_if.sv]
// request channel: texel write or sample command
`default_nettype none

interface bts_req_if import bts_pkg::*; ;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [ADDR_IN_W-1:0]        texel_address;
   logic [TEXEL_W-1:0]          texel_value;
   logic signed [COORD_W-1:0]   coord_u;
   logic signed [COORD_W-1:0]   coord_v;

   modport source (output valid, command, texel_address, texel_value, coord_u, coord_v,
                   input ready);
   modport sink   (input valid, command, texel_address, texel_value, coord_u, coord_v,
                   output ready);
endinterface

`default_nettype wire

[src/bts_rsp_if.sv]
// response channel: sample result or write acknowledge
`default_nettype none

interface bts_rsp_if import bts_pkg::*; ;
   logic                valid;
   logic                ready;
   logic                was_sample;
   logic [RESULT_W-1:0] channel_0;
   logic [RESULT_W-1:0] channel_1;
   logic [RESULT_W-1:0] channel_2;
   logic [RESULT_W-1:0] channel_3;

   modport source (output valid, was_sample, channel_0, channel_1, channel_2, channel_3,
                   input ready);
   modport sink   (input valid, was_sample, channel_0, channel_1, channel_2, channel_3,
                   output ready);
endinterface

`default_nettype wire

[src/bts_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module bts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/bts_addr.sv]
// texel index, wrap and address reduction pipeline
`default_nettype none

module bts_addr import bts_pkg::*; #(
   parameter int TEXEL_COUNT   = TEXEL_COUNT_DEF,
   parameter int MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF,
   localparam int IW = (TEXEL_COUNT > 1) ? $clog2(TEXEL_COUNT) : 1
) (
   input  wire logic                               clock,
   input  wire logic                               adv,
   input  wire logic                               command,
   input  wire logic [ADDR_IN_W-1:0]               texel_address,
   input  wire logic [TEXEL_W-1:0]                 texel_value,
   input  wire logic [FRAC_W-1:0]                  frac_u,
   input  wire logic [FRAC_W-1:0]                  frac_v,
   input  wire logic [CSR_DATA_W-1:0]              width_log2,
   input  wire logic [CSR_DATA_W-1:0]              height_log2,
   output      bts_ctl_type                        ctl_s3,
   output      logic                               wr_en_s3,
   output      logic [IW-1:0]                      wr_idx_s3,
   output      logic [TEXEL_W-1:0]                 wr_data_s3,
   output      logic [TAP_COUNT-1:0][IW-1:0]       rd_idx
);

   localparam int XW = (MAX_SIZE_LOG2 > 0) ? MAX_SIZE_LOG2 : 1;
   localparam int SW = ($clog2(MAX_SIZE_LOG2 + 1) > 0) ? $clog2(MAX_SIZE_LOG2 + 1) : 1;
   localparam int AW = 2 * XW + 1;
   localparam int LG = $clog2(TEXEL_COUNT);
   localparam int K  = AW + LG;
   localparam int MW = AW + 1;
   localparam int PW = AW + MW;
   localparam int EW = ((AW > IW) ? AW : IW) + 1;
   localparam longint unsigned RECIP_L = (64'd1 << K) / TEXEL_COUNT;
   localparam logic [MW-1:0] RECIP   = MW'(RECIP_L);
   localparam logic [EW-1:0] COUNT_E = EW'(TEXEL_COUNT);

   function automatic logic [AW-1:0] texel_addr(input logic [XW-1:0] row,
                                               input logic [XW-1:0] col,
                                               input logic [SW-1:0] sh);
      return (AW'(row) << sh) + AW'(col);
   endfunction

   // stage 1: texel indices and raw addresses
   logic [SW-1:0]              wl;
   logic [SW-1:0]              hl;
   logic [XW-1:0]              wmask;
   logic [XW-1:0]              hmask;
   logic [XW+FRAC_W-1:0]       su;
   logic [XW+FRAC_W-1:0]       sv;
   logic [XW-1:0]              x1;
   logic [XW-1:0]              x2;
   logic [XW-1:0]              y1;
   logic [XW-1:0]              y2;

   logic [TAP_COUNT-1:0][AW-1:0] addr_s1_in, addr_s1_ff;
   bts_ctl_type                  ctl_s1_in, ctl_s1_ff;
   logic                         wr_en_s1_in, wr_en_s1_ff;
   logic [IW-1:0]                wr_idx_s1_in, wr_idx_s1_ff;
   logic [TEXEL_W-1:0]           wr_data_s1_ff;

   always_comb begin
      wl    = (32'(width_log2) > MAX_SIZE_LOG2) ? SW'(MAX_SIZE_LOG2) : SW'(width_log2);
      hl    = (32'(height_log2) > MAX_SIZE_LOG2) ? SW'(MAX_SIZE_LOG2) : SW'(height_log2);
      wmask = XW'(((XW + 1)'(1) << wl) - (XW + 1)'(1));
      hmask = XW'(((XW + 1)'(1) << hl) - (XW + 1)'(1));
      su    = (XW + FRAC_W)'(frac_u) << wl;
      sv    = (XW + FRAC_W)'(frac_v) << hl;
      x1    = XW'(su >> FRAC_W) & wmask;
      y1    = XW'(sv >> FRAC_W) & hmask;
      x2    = (x1 + XW'(1)) & wmask;
      y2    = (y1 + XW'(1)) & hmask;

      addr_s1_in[0] = texel_addr(y1, x1, wl);
      addr_s1_in[1] = texel_addr(y1, x2, wl);
      addr_s1_in[2] = texel_addr(y2, x1, wl);
      addr_s1_in[3] = texel_addr(y2, x2, wl);

      ctl_s1_in.is_sample = (command == CMD_SAMPLE);
      ctl_s1_in.dx        = su[FRAC_W-1:0];
      ctl_s1_in.dy        = sv[FRAC_W-1:0];

      wr_en_s1_in  = (command == CMD_WRITE) && (32'(texel_address) < TEXEL_COUNT);
      wr_idx_s1_in = IW'(texel_address);
   end

   // stage 2: multiply by the reciprocal of the texel count
   logic [TAP_COUNT-1:0][AW-1:0] addr_s2_ff;
   logic [TAP_COUNT-1:0][PW-1:0] prod_s2_in, prod_s2_ff;
   bts_ctl_type                  ctl_s2_ff;
   logic                         wr_en_s2_ff;
   logic [IW-1:0]                wr_idx_s2_ff;
   logic [TEXEL_W-1:0]           wr_data_s2_ff;

   always_comb begin
      for (int k = 0; k < TAP_COUNT; k++) begin
         prod_s2_in[k] = PW'(addr_s1_ff[k]) * PW'(RECIP);
      end
   end

   // stage 3: remainder, at most one count too large
   logic [TAP_COUNT-1:0][AW-1:0] quot;
   logic [TAP_COUNT-1:0][EW-1:0] rem_s3_in, rem_s3_ff;
   bts_ctl_type                  ctl_s3_ff;
   logic                         wr_en_s3_ff;
   logic [IW-1:0]                wr_idx_s3_ff;
   logic [TEXEL_W-1:0]           wr_data_s3_ff;

   always_comb begin
      for (int k = 0; k < TAP_COUNT; k++) begin
         quot[k]      = AW'(prod_s2_ff[k] >> K);
         rem_s3_in[k] = EW'(addr_s2_ff[k]) - EW'(EW'(quot[k]) * COUNT_E);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         addr_s1_ff    <= addr_s1_in;
         ctl_s1_ff     <= ctl_s1_in;
         wr_en_s1_ff   <= wr_en_s1_in;
         wr_idx_s1_ff  <= wr_idx_s1_in;
         wr_data_s1_ff <= texel_value;

         addr_s2_ff    <= addr_s1_ff;
         prod_s2_ff    <= prod_s2_in;
         ctl_s2_ff     <= ctl_s1_ff;
         wr_en_s2_ff   <= wr_en_s1_ff;
         wr_idx_s2_ff  <= wr_idx_s1_ff;
         wr_data_s2_ff <= wr_data_s1_ff;

         rem_s3_ff     <= rem_s3_in;
         ctl_s3_ff     <= ctl_s2_ff;
         wr_en_s3_ff   <= wr_en_s2_ff;
         wr_idx_s3_ff  <= wr_idx_s2_ff;
         wr_data_s3_ff <= wr_data_s2_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < TAP_COUNT; k++) begin
         rd_idx[k] = (rem_s3_ff[k] >= COUNT_E) ? IW'(rem_s3_ff[k] - COUNT_E)
                                               : IW'(rem_s3_ff[k]);
      end
   end

   assign ctl_s3     = ctl_s3_ff;
   assign wr_en_s3   = wr_en_s3_ff;
   assign wr_idx_s3  = wr_idx_s3_ff;
   assign wr_data_s3 = wr_data_s3_ff;

endmodule

`default_nettype wire

[src/bts_filter.sv]
// two pass bilinear interpolation of the four fetched texels
`default_nettype none

module bts_filter import bts_pkg::*; (
   input  wire logic         clock,
   input  wire logic         adv,
   input  wire logic         out_load,
   input  wire bts_ctl_type  ctl_s3,
   input  wire bts_taps_type taps,
   output      logic         was_sample,
   output      bts_chan_type channels
);

   bts_ctl_type ctl_s4_ff, ctl_s5_ff, ctl_s6_ff;

   // along x
   logic [WEIGHT_W-1:0]                 wx;
   logic [CHAN_COUNT-1:0][LERP_W-1:0]   top_s5_in, top_s5_ff;
   logic [CHAN_COUNT-1:0][LERP_W-1:0]   bot_s5_in, bot_s5_ff;

   always_comb begin
      wx = WEIGHT_ONE - WEIGHT_W'(ctl_s4_ff.dx);
      for (int c = 0; c < CHAN_COUNT; c++) begin
         top_s5_in[c] = LERP_W'(
            (LERP_W + 1)'(taps[0][c*CHAN_W +: CHAN_W]) * (LERP_W + 1)'(wx) +
            (LERP_W + 1)'(taps[1][c*CHAN_W +: CHAN_W]) * (LERP_W + 1)'(ctl_s4_ff.dx));
         bot_s5_in[c] = LERP_W'(
            (LERP_W + 1)'(taps[2][c*CHAN_W +: CHAN_W]) * (LERP_W + 1)'(wx) +
            (LERP_W + 1)'(taps[3][c*CHAN_W +: CHAN_W]) * (LERP_W + 1)'(ctl_s4_ff.dx));
      end
   end

   // along y
   logic [WEIGHT_W-1:0]                 wy;
   logic [CHAN_COUNT-1:0][PROD_W-1:0]   ptop_s6_in, ptop_s6_ff;
   logic [CHAN_COUNT-1:0][PROD_W-1:0]   pbot_s6_in, pbot_s6_ff;

   always_comb begin
      wy = WEIGHT_ONE - WEIGHT_W'(ctl_s5_ff.dy);
      for (int c = 0; c < CHAN_COUNT; c++) begin
         ptop_s6_in[c] = PROD_W'(top_s5_ff[c]) * PROD_W'(wy);
         pbot_s6_in[c] = PROD_W'(bot_s5_ff[c]) * PROD_W'(ctl_s5_ff.dy);
      end
   end

   // round to q8.8
   logic [PROD_W-1:0]  sum;
   logic               was_sample_in, was_sample_ff;
   bts_chan_type       chan_in, chan_ff;

   always_comb begin
      was_sample_in = ctl_s6_ff.is_sample;
      sum           = '0;
      for (int c = 0; c < CHAN_COUNT; c++) begin
         sum        = ptop_s6_ff[c] + pbot_s6_ff[c] + ROUND_HALF;
         chan_in[c] = ctl_s6_ff.is_sample ? sum[ROUND_POS +: RESULT_W] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_s4_ff  <= ctl_s3;
         ctl_s5_ff  <= ctl_s4_ff;
         top_s5_ff  <= top_s5_in;
         bot_s5_ff  <= bot_s5_in;
         ctl_s6_ff  <= ctl_s5_ff;
         ptop_s6_ff <= ptop_s6_in;
         pbot_s6_ff <= pbot_s6_in;
      end
      if (out_load) begin
         was_sample_ff <= was_sample_in;
         chan_ff       <= chan_in;
      end
   end

   assign was_sample = was_sample_ff;
   assign channels   = chan_ff;

endmodule

`default_nettype wire

[src/bilinear_texture_sampler_top.sv]
// bilinear texture sampler with repeat addressing, top level
// throughput: one write or sample per cycle unless the receiver stalls a held result;
// four texture ram copies give each tap a read port, and every write goes to all four
// reset: clears the pipeline valids and both size registers (1x1 texture);
// texture ram is not cleared and holds no defined data until written
`default_nettype none

module bilinear_texture_sampler_top import bts_pkg::*; #(
   parameter int TEXEL_COUNT   = TEXEL_COUNT_DEF,
   parameter int MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bts_req_if.sink                     req_bus,
   bts_rsp_if.source                   rsp_bus,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IW = (TEXEL_COUNT > 1) ? $clog2(TEXEL_COUNT) : 1;
   localparam int STAGES = 6;

   // size registers
   logic [CSR_DATA_W-1:0] width_log2_in, width_log2_ff;
   logic [CSR_DATA_W-1:0] height_log2_in, height_log2_ff;

   always_comb begin
      width_log2_in  = width_log2_ff;
      height_log2_in = height_log2_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WIDTH_LOG2: begin
               width_log2_in = csr_wdata;
            end
            CSR_HEIGHT_LOG2: begin
               height_log2_in = csr_wdata;
            end
            default: begin
               width_log2_in = width_log2_ff;
            end
         endcase
      end
   end

   // pipeline control
   logic [STAGES:1] stage_v_in, stage_v_ff;
   logic            out_v_in, out_v_ff;
   logic            adv;
   logic            out_load;

   assign adv      = !(out_v_ff && !rsp_bus.ready && stage_v_ff[STAGES]);
   assign out_load = adv && stage_v_ff[STAGES];

   always_comb begin
      stage_v_in = adv ? {stage_v_ff[STAGES-1:1], req_bus.valid} : stage_v_ff;
      if (out_load) begin
         out_v_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff  <= '0;
         height_log2_ff <= '0;
         stage_v_ff     <= '0;
         out_v_ff       <= 1'b0;
      end else begin
         width_log2_ff  <= width_log2_in;
         height_log2_ff <= height_log2_in;
         stage_v_ff     <= stage_v_in;
         out_v_ff       <= out_v_in;
      end
   end

   assign req_bus.ready = adv;

   // address pipeline
   bts_ctl_type                  ctl_s3;
   logic                         wr_en_s3;
   logic [IW-1:0]                wr_idx_s3;
   logic [TEXEL_W-1:0]           wr_data_s3;
   logic [TAP_COUNT-1:0][IW-1:0] rd_idx;

   bts_addr #(
      .TEXEL_COUNT   (TEXEL_COUNT),
      .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
   ) u_addr (
      .clock         (clock),
      .adv           (adv),
      .command       (req_bus.command),
      .texel_address (req_bus.texel_address),
      .texel_value   (req_bus.texel_value),
      .frac_u        (req_bus.coord_u[FRAC_W-1:0]),
      .frac_v        (req_bus.coord_v[FRAC_W-1:0]),
      .width_log2    (width_log2_ff),
      .height_log2   (height_log2_ff),
      .ctl_s3        (ctl_s3),
      .wr_en_s3      (wr_en_s3),
      .wr_idx_s3     (wr_idx_s3),
      .wr_data_s3    (wr_data_s3),
      .rd_idx        (rd_idx)
   );

   // texture ram copies
   logic         ram_we;
   bts_taps_type taps;

   assign ram_we = adv && stage_v_ff[3] && wr_en_s3;

   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
      bts_ram #(
         .WIDTH (TEXEL_W),
         .DEPTH (TEXEL_COUNT)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_we),
         .wr_addr (wr_idx_s3),
         .wr_data (wr_data_s3),
         .rd_en   (adv),
         .rd_addr (rd_idx[k]),
         .rd_data (taps[k])
      );
   end

   // interpolation
   logic         was_sample;
   bts_chan_type channels;

   bts_filter u_filter (
      .clock      (clock),
      .adv        (adv),
      .out_load   (out_load),
      .ctl_s3     (ctl_s3),
      .taps       (taps),
      .was_sample (was_sample),
      .channels   (channels)
   );

   assign rsp_bus.valid      = out_v_ff;
   assign rsp_bus.was_sample = was_sample;
   assign rsp_bus.channel_0  = channels[0];
   assign rsp_bus.channel_1  = channels[1];
   assign rsp_bus.channel_2  = channels[2];
   assign rsp_bus.channel_3  = channels[3];

   // checks
   a_ram_write_only_for_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (stage_v_ff[3] && !ctl_s3.is_sample))
      else $error("texture ram written by a sample");

   a_stall_holds_stages: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(stage_v_ff))
      else $error("pipeline moved during a stall");

   a_accept_enters_stage: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> stage_v_ff[1])
      else $error("accepted beat lost at first stage");

   a_read_index_in_range: assert property (@(posedge clock) disable iff (reset)
      stage_v_ff[3] |-> ((32'(rd_idx[0]) < TEXEL_COUNT) && (32'(rd_idx[1]) < TEXEL_COUNT) &&
                         (32'(rd_idx[2]) < TEXEL_COUNT) && (32'(rd_idx[3]) < TEXEL_COUNT)))
      else $error("texel read index not reduced");

   a_write_ack_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.was_sample) |->
         (rsp_bus.channel_0 == '0 && rsp_bus.channel_1 == '0 &&
          rsp_bus.channel_2 == '0 && rsp_bus.channel_3 == '0))
      else $error("write acknowledge carries channel data");

endmodule

`default_nettype wire

[sim/tb.sv]
// testbench for the bilinear texture sampler: random texel loads and samples against a predictor
`timescale 1ns / 100ps

module tb;
   import bts_pkg::*;

   localparam int   STALL_LIMIT  = 1000;
   localparam int   TAIL_CYCLES  = 12;
   localparam int   PHASE_ITEMS  = 100;

   typedef struct packed {
      logic                      command;
      logic [ADDR_IN_W-1:0]      addr;
      logic [TEXEL_W-1:0]        value;
      logic [COORD_W-1:0]        u;
      logic [COORD_W-1:0]        v;
   } texel_cmd_type;

   typedef struct packed {
      logic         was_sample;
      bts_chan_type chan;
   } filtered_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bts_req_if req_bus();
   bts_rsp_if rsp_bus();

   bilinear_texture_sampler_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   texel_cmd_type  cmd_q[$];
   filtered_type   filtered_q[$];
   logic [TEXEL_W-1:0] texture_shadow [0:TEXEL_COUNT_DEF-1];
   bit          texel_loaded [0:TEXEL_COUNT_DEF-1];
   logic [3:0]  size_w, size_h;
   logic [3:0]  gen_w, gen_h;
   int          mismatches = 0;

   function automatic int unsigned eff_log2(input logic [3:0] r);
      return (r > MAX_SIZE_LOG2_DEF) ? MAX_SIZE_LOG2_DEF : r;
   endfunction

   // tap order: (y1,x1) (y1,x2) (y2,x1) (y2,x2)
   function automatic void tap_layout(input logic [3:0] w_reg, input logic [3:0] h_reg,
         input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
         output logic [3:0][ADDR_IN_W-1:0] addr, output logic [63:0] dx,
         output logic [63:0] dy);
      int unsigned wl, hl;
      logic [31:0] su, sv, x1, x2, y1, y2, wmask, hmask;
      wl = eff_log2(w_reg);
      hl = eff_log2(h_reg);
      wmask = (32'd1 << wl) - 32'd1;
      hmask = (32'd1 << hl) - 32'd1;
      su = {16'd0, u[15:0]} << wl;
      sv = {16'd0, v[15:0]} << hl;
      x1 = (su >> 16) & wmask;
      y1 = (sv >> 16) & hmask;
      x2 = (x1 + 32'd1) & wmask;
      y2 = (y1 + 32'd1) & hmask;
      dx = {48'd0, su[15:0]};
      dy = {48'd0, sv[15:0]};
      addr[0] = ADDR_IN_W'((y1 << wl) + x1);
      addr[1] = ADDR_IN_W'((y1 << wl) + x2);
      addr[2] = ADDR_IN_W'((y2 << wl) + x1);
      addr[3] = ADDR_IN_W'((y2 << wl) + x2);
   endfunction

   function automatic filtered_type filter_cmd(input texel_cmd_type c);
      filtered_type r;
      logic [3:0][ADDR_IN_W-1:0] addr;
      logic [3:0][TEXEL_W-1:0]   tap;
      logic [63:0] dx, dy, top, bot, acc;
      r = '0;
      if (c.command == CMD_WRITE) begin
         texture_shadow[c.addr] = c.value;
      end else begin
         tap_layout(size_w, size_h, c.u, c.v, addr, dx, dy);
         for (int i = 0; i < TAP_COUNT; i++) tap[i] = texture_shadow[addr[i]];
         r.was_sample = 1'b1;
         for (int k = 0; k < CHAN_COUNT; k++) begin
            top = 64'(tap[0][8*k +: 8]) * (64'd65536 - dx) + 64'(tap[1][8*k +: 8]) * dx;
            bot = 64'(tap[2][8*k +: 8]) * (64'd65536 - dx) + 64'(tap[3][8*k +: 8]) * dx;
            acc = top * (64'd65536 - dy) + bot * dy;
            r.chan[k] = RESULT_W'((acc + 64'd8388608) >> 24);
         end
      end
      return r;
   endfunction

   // csr shadow
   always @(posedge clock) begin
      if (reset) begin
         size_w <= '0;
         size_h <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH_LOG2:  size_w <= csr_wdata;
            CSR_HEIGHT_LOG2: size_h <= csr_wdata;
            default: ;
         endcase
      end
   end

   // driver
   texel_cmd_type cur_cmd;
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) filtered_q = {filtered_q, filter_cmd(cur_cmd)};
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
               cur_cmd = cmd_q.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.command       <= cur_cmd.command;
               req_bus.texel_address <= cur_cmd.addr;
               req_bus.texel_value   <= cur_cmd.value;
               req_bus.coord_u       <= cur_cmd.u;
               req_bus.coord_v       <= cur_cmd.v;
               burst_left = burst_left - 1;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall pattern
   logic [7:0]  stall_tick = '0;
   logic [15:0] stall_mask = 16'hFFFF;

   always @(posedge clock) begin
      filtered_type exp_beat;
      bts_chan_type got;
      stall_tick <= stall_tick + 8'd1;
      if (stall_tick == 8'd0)
         stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      rsp_bus.ready <= stall_mask[stall_tick[3:0]];
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.channel_3, rsp_bus.channel_2, rsp_bus.channel_1, rsp_bus.channel_0};
         if (filtered_q.size() == 0) begin
            $error("unexpected result beat: was_sample %0d", rsp_bus.was_sample);
            mismatches++;
         end else begin
            exp_beat = filtered_q.pop_front();
            if (rsp_bus.was_sample !== exp_beat.was_sample) begin
               $error("was_sample: expected %0d, actual %0d", exp_beat.was_sample,
                      rsp_bus.was_sample);
               mismatches++;
            end
            for (int k = 0; k < CHAN_COUNT; k++) begin
               if (got[k] !== exp_beat.chan[k]) begin
                  $error("channel_%0d: expected %0d, actual %0d", k, exp_beat.chan[k], got[k]);
                  mismatches++;
               end
            end
         end
      end
   end

   // watchdog
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (cmd_q.size() == 0 && filtered_q.size() == 0 && !req_bus.valid)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus
   function automatic logic [TEXEL_W-1:0] rand_texel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return {16'($urandom), 16'h0000};
         1: return {16'($urandom), 16'hFFFF};
         2: return {16'($urandom), 16'($urandom_range(0, 255))};
         default: return $urandom;
      endcase
   endfunction

   task automatic push_write(input logic [ADDR_IN_W-1:0] a, input logic [TEXEL_W-1:0] d);
      texel_cmd_type c;
      c.command = CMD_WRITE;
      c.addr    = a;
      c.value   = d;
      c.u       = $urandom;
      c.v       = $urandom;
      cmd_q = {cmd_q, c};
      texel_loaded[a] = 1'b1;
   endtask

   // loads any tap not yet written before the sample itself
   task automatic push_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
      texel_cmd_type c;
      logic [3:0][ADDR_IN_W-1:0] addr;
      logic [63:0] dx, dy;
      tap_layout(gen_w, gen_h, u, v, addr, dx, dy);
      for (int i = 0; i < TAP_COUNT; i++)
         if (!texel_loaded[addr[i]]) push_write(addr[i], rand_texel());
      c.command = CMD_SAMPLE;
      c.addr    = ADDR_IN_W'($urandom);
      c.value   = $urandom;
      c.u       = u;
      c.v       = v;
      cmd_q = {cmd_q, c};
   endtask

   task automatic drain();
      while (cmd_q.size() != 0 || req_bus.valid || filtered_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_size(input logic [3:0] w, input logic [3:0] h);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_WIDTH_LOG2;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_HEIGHT_LOG2;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      gen_w = w;
      gen_h = h;
   endtask

   task automatic random_phase(input int n);
      int unsigned region_log2;
      int pick;
      region_log2 = eff_log2(gen_w) + eff_log2(gen_h);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            push_sample(rand_coord(), rand_coord());
         else if (pick < 85)
            push_write(ADDR_IN_W'($urandom_range(0, (1 << region_log2) - 1)), rand_texel());
         else
            push_write(ADDR_IN_W'($urandom), rand_texel());
      end
   endtask

   logic [3:0] plan_w [8] = '{4'd0, 4'd8, 4'd15, 4'd8, 4'd0, 4'd9, 4'd3, 4'd1};
   logic [3:0] plan_h [8] = '{4'd0, 4'd8, 4'd15, 4'd0, 4'd8, 4'd3, 4'd2, 4'd1};

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_WRITE;
      req_bus.texel_address = '0;
      req_bus.texel_value = '0;
      req_bus.coord_u = '0;
      req_bus.coord_v = '0;
      rsp_bus.ready = 1'b0;
      gen_w = '0;
      gen_h = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // 1x1 texture straight after reset
      push_write(16'h0000, 32'hFFFF_FFFF);
      push_sample(32'h0000_0000, 32'h0000_0000);
      push_sample(32'h7FFF_FFFF, 32'h8000_0000);
      push_write(16'h0000, 32'h0000_0000);
      push_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_write(16'hFFFF, 32'h80FF_0140);
      push_write(16'h0000, 32'h1234_5678);
      push_sample(32'h0000_8000, 32'h0000_FFFF);
      drain();

      // 2x1 texture: exact half rounds up, wrap of the right neighbour
      set_size(4'd1, 4'd0);
      push_write(16'h0000, 32'h0000_0000);
      push_write(16'h0001, 32'h0101_0101);
      push_sample(32'h0000_0040, 32'h0000_0000);
      push_sample(32'h0000_8000, 32'h0000_0000);
      push_sample(32'h0000_FFFF, 32'h1234_5678);
      push_sample(32'hFFFF_FFC0, 32'h8000_7FFF);
      drain();

      for (int p = 0; p < 10; p++) begin
         if (p < 8)
            set_size(plan_w[p], plan_h[p]);
         else
            set_size(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         random_phase(PHASE_ITEMS);
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
